// ===== hw/rtl/lfrb_pkg.sv =====
// line framing ring buffer package: opcodes, character codes, fsm state type
// and default sizing; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfrb_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int BYTE_W    = 8;

	localparam logic [1:0] OP_PUSH     = 2'd0;
	localparam logic [1:0] OP_PUSH_SEP = 2'd1;
	localparam logic [1:0] OP_POP      = 2'd2;

	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEP,
		ST_POP
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfrb_ram.sv =====
// generic simple dual-port ram: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lfrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/line_framing_ring_buffer.sv =====
// line framing ring buffer top level: byte fifo in lfrb_ram, control fsm, output register
// push byte: result the cycle after accept; push with separator: separator write and
// result in ST_SEP; pop: no-line result the cycle after accept, else ram read on accept,
// first byte in ST_POP, one byte per cycle unless stalled; next accept once fsm is idle
// reset clears pointers, fill and newline counts and the output valid; ram holds no reset
`timescale 1ns / 1ps
`default_nettype none

module line_framing_ring_buffer #(
	parameter int DEPTH = lfrb_pkg::DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic [2:0] s_tuser,   // [1:0] opcode, [2] sep_newline
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [7:0] out_byte
	output logic            m_tlast,   // last_of_run
	output logic      [1:0] m_tuser    // [0] no_line, [1] overflow
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lfrb_pkg::state_t state_q, state_d;

	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] nl_q, nl_d;

	logic sep_q, drop_q;

	logic                        out_valid_q;
	logic [lfrb_pkg::BYTE_W-1:0] out_byte_q;
	logic                        out_last_q, out_noline_q, out_ovf_q;

	logic                        ld, ld_last, ld_noline, ld_ovf;
	logic [lfrb_pkg::BYTE_W-1:0] ld_byte;

	logic                        we, re;
	logic [AW-1:0]               waddr, raddr;
	logic [lfrb_pkg::BYTE_W-1:0] wdata, rdata;

	logic          out_free, accept, has_room;
	logic [AW-1:0] wr_ptr_nx, rd_ptr_nx;
	logic [1:0]    opcode;
	logic [lfrb_pkg::BYTE_W-1:0] sep_byte;

	assign opcode    = s_tuser[1:0];
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == lfrb_pkg::ST_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign has_room  = (fill_q != CW'(DEPTH));
	assign wr_ptr_nx = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign rd_ptr_nx = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
	assign sep_byte  = sep_q ? lfrb_pkg::CH_NEWLINE : lfrb_pkg::CH_SPACE;

	lfrb_ram #(
		.WIDTH(lfrb_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d   = state_q;
		wr_ptr_d  = wr_ptr_q;
		rd_ptr_d  = rd_ptr_q;
		fill_d    = fill_q;
		nl_d      = nl_q;
		we        = 1'b0;
		waddr     = wr_ptr_q;
		wdata     = s_tdata;
		re        = 1'b0;
		raddr     = rd_ptr_q;
		ld        = 1'b0;
		ld_byte   = '0;
		ld_last   = 1'b1;
		ld_noline = 1'b0;
		ld_ovf    = 1'b0;
		unique case (state_q)
			lfrb_pkg::ST_IDLE: begin
				if (accept && (opcode == lfrb_pkg::OP_PUSH ||
						opcode == lfrb_pkg::OP_PUSH_SEP)) begin
					if (has_room) begin
						we       = 1'b1;
						wr_ptr_d = wr_ptr_nx;
						fill_d   = fill_q + CW'(1);
						if (s_tdata == lfrb_pkg::CH_NEWLINE) begin
							nl_d = nl_q + CW'(1);
						end
					end
					if (opcode == lfrb_pkg::OP_PUSH) begin
						ld     = 1'b1;
						ld_ovf = !has_room;
					end else begin
						state_d = lfrb_pkg::ST_SEP;
					end
				end else if (accept && opcode == lfrb_pkg::OP_POP) begin
					if (nl_q == '0) begin
						ld        = 1'b1;
						ld_noline = 1'b1;
					end else begin
						re      = 1'b1;
						state_d = lfrb_pkg::ST_POP;
					end
				end
			end
			lfrb_pkg::ST_SEP: begin
				if (out_free) begin
					wdata = sep_byte;
					if (has_room) begin
						we       = 1'b1;
						wr_ptr_d = wr_ptr_nx;
						fill_d   = fill_q + CW'(1);
						if (sep_q) begin
							nl_d = nl_q + CW'(1);
						end
					end
					ld      = 1'b1;
					ld_ovf  = drop_q || !has_room;
					state_d = lfrb_pkg::ST_IDLE;
				end
			end
			lfrb_pkg::ST_POP: begin
				// rdata holds the byte at rd_ptr_q until the next read is issued
				if (out_free) begin
					ld       = 1'b1;
					ld_byte  = rdata;
					ld_last  = (rdata == lfrb_pkg::CH_NEWLINE);
					rd_ptr_d = rd_ptr_nx;
					fill_d   = fill_q - CW'(1);
					if (rdata == lfrb_pkg::CH_NEWLINE) begin
						nl_d    = nl_q - CW'(1);
						state_d = lfrb_pkg::ST_IDLE;
					end else begin
						re    = 1'b1;
						raddr = rd_ptr_nx;
					end
				end
			end
			default: begin
				state_d = lfrb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfrb_pkg::ST_IDLE;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			nl_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			fill_q   <= fill_d;
			nl_q     <= nl_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sep_q  <= s_tuser[2];
			drop_q <= !has_room;
		end
		if (ld) begin
			out_byte_q   <= ld_byte;
			out_last_q   <= ld_last;
			out_noline_q <= ld_noline;
			out_ovf_q    <= ld_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_noline_q};

endmodule

`default_nettype wire

// ===== bench/line_framing_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// testbench for line_framing_ring_buffer: text pushes and line pops are checked item by item
// against a ring model kept in a small scoreboard class; needs lfrb_pkg and the block itself

module line_framing_ring_buffer_tb;
	import lfrb_pkg::*;

	localparam int         RING_DEPTH = DEPTH_DEF;
	localparam int         RING_AW    = $clog2(RING_DEPTH);
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         LONG_HOLD  = 400;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       no_line;
		logic       overflow;
	} line_result_t;

	class line_scoreboard;
		logic [7:0]   ring [RING_DEPTH];
		int unsigned  wr_ptr;
		int unsigned  rd_ptr;
		int unsigned  fill;
		int unsigned  nl_count;
		line_result_t results_due [$];
		int           errors;

		function new();
			wr_ptr   = 0;
			rd_ptr   = 0;
			fill     = 0;
			nl_count = 0;
			errors   = 0;
		endfunction

		// returns 1 when the byte had to be dropped
		function bit store_byte(logic [7:0] b);
			if (fill >= RING_DEPTH)
				return 1'b1;
			ring[RING_AW'(wr_ptr)] = b;
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			fill++;
			if (b == CH_NEWLINE)
				nl_count++;
			return 1'b0;
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] data, logic sep_nl);
			bit         dropped;
			logic [7:0] b;
			case (op)
				OP_PUSH, OP_PUSH_SEP: begin
					dropped = store_byte(data);
					if (op == OP_PUSH_SEP) begin
						if (store_byte(sep_nl ? CH_NEWLINE : CH_SPACE))
							dropped = 1'b1;
					end
					results_due.push_back('{8'h00, 1'b1, 1'b0, dropped});
				end
				OP_POP: begin
					if (nl_count == 0) begin
						results_due.push_back('{8'h00, 1'b1, 1'b1, 1'b0});
					end else begin
						do begin
							b = ring[RING_AW'(rd_ptr)];
							rd_ptr = (rd_ptr + 1) % RING_DEPTH;
							fill--;
							if (b == CH_NEWLINE)
								nl_count--;
							results_due.push_back('{b, b == CH_NEWLINE, 1'b0, 1'b0});
						end while (b != CH_NEWLINE);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(line_result_t got);
			line_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item: byte %02h last %b no_line %b overflow %b",
						got.out_byte, got.last, got.no_line, got.overflow);
				return;
			end
			want = results_due.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch byte/last/no_line/ovf: exp %02h %b %b %b, got %02h %b %b %b",
						want.out_byte, want.last, want.no_line, want.overflow,
						got.out_byte, got.last, got.no_line, got.overflow);
			end
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic [2:0] s_tuser  = 3'b000;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	bit             long_stall_req = 1'b0;
	int             burst_left     = 0;
	int             text_items     = 0;
	line_scoreboard sb             = new();

	always #5 clk = ~clk;

	line_framing_ring_buffer #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always @(posedge clk) begin : result_monitor
		line_result_t seen;
		if (m_tvalid && m_tready) begin
			seen = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
			sb.check_result(seen);
		end
	end

	// receiver: segments of random stall modes, plus one long hold-off on request
	initial begin : receiver
		int stall_mode;
		int seg_left;
		int hold;
		stall_mode = 0;
		seg_left   = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_tready <= 1'b0;
				for (hold = 0; hold < LONG_HOLD; hold++)
					@(posedge clk);
			end
			if (seg_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				seg_left   = $urandom_range(8, 80);
			end
			seg_left--;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= seg_left[2];
			endcase
		end
	end

	task automatic send_item(logic [1:0] op, logic [7:0] data, logic sep_nl);
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= {sep_nl, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(op, data, sep_nl);
		if (op != OP_UNUSED)
			text_items++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending() != 0);
	endtask

	task automatic send_random_text();
		int pick;
		pick = $urandom_range(0, 99);
		// never let the ring fill up with no line end in it
		if (sb.nl_count == 0 && sb.fill >= RING_DEPTH - 3)
			send_item(OP_PUSH, CH_NEWLINE, 1'($urandom_range(0, 1)));
		else if (pick < 6)
			send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		else if (pick < 22)
			send_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		else if (pick < 40)
			send_item(OP_PUSH_SEP, 8'($urandom_range(0, 255)), $urandom_range(0, 2) != 0);
		else if (pick < 45)
			send_item(OP_PUSH, CH_NEWLINE, 1'($urandom_range(0, 1)));
		else
			send_item(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic push_line(int len);
		repeat (len - 1)
			send_item(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0);
		send_item(OP_PUSH_SEP, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// fill the ring, push into it while full, then read every line back
	task automatic fill_to_overflow();
		logic [7:0] b;
		while (sb.fill < RING_DEPTH - 1) begin
			if ($urandom_range(0, 7) == 0 || (sb.nl_count == 0 && sb.fill >= RING_DEPTH - 3))
				b = CH_NEWLINE;
			else
				b = 8'($urandom_range(0, 255));
			send_item(OP_PUSH, b, 1'($urandom_range(0, 1)));
		end
		// one slot left: the data byte fits, the newline separator is dropped
		send_item(OP_PUSH_SEP, 8'($urandom_range(0, 255)), 1'b1);
		send_item(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0);
		send_item(OP_PUSH_SEP, 8'($urandom_range(0, 255)), 1'b0);
		send_item(OP_PUSH, CH_NEWLINE, 1'b1);
		while (sb.nl_count != 0)
			send_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		send_item(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP, 8'h00, 1'b0);          // empty ring
		send_item(OP_PUSH, 8'h00, 1'b0);
		send_item(OP_PUSH, 8'hFF, 1'b1);
		send_item(OP_PUSH_SEP, 8'h55, 1'b0);     // space separator
		send_item(OP_PUSH_SEP, 8'hAA, 1'b1);     // newline separator
		send_item(OP_UNUSED, 8'hFF, 1'b1);
		send_item(OP_POP, 8'hFF, 1'b1);
		send_item(OP_POP, 8'h00, 1'b0);
		send_item(OP_PUSH, CH_NEWLINE, 1'b0);    // newline as data ends a line
		send_item(OP_PUSH_SEP, CH_NEWLINE, 1'b1);
		send_item(OP_PUSH, CH_SPACE, 1'b0);
		send_item(OP_UNUSED, 8'h00, 1'b0);
		send_item(OP_POP, 8'h0F, 1'b0);
		send_item(OP_POP, 8'hF0, 1'b1);
		send_item(OP_POP, 8'h3C, 1'b0);
		send_item(OP_POP, 8'hC3, 1'b1);          // only a space left
		wait_drained();

		fill_to_overflow();
		while (text_items < 110)
			send_random_text();

		// sender pauses, then the receiver holds off while items keep coming
		wait_drained();
		push_line(12);
		push_line(5);
		long_stall_req = 1'b1;
		send_item(OP_POP, 8'($urandom_range(0, 255)), 1'b0);
		while (text_items < 220)
			send_random_text();

		fill_to_overflow();
		while (text_items < 300)
			send_random_text();

		wait_drained();
		repeat (20)
			@(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
